// File: rtl/css_pkg.sv
// Package for the clocked step sequencer: item structs, request, register and motion codes,
// the LFSR constants and the sequencer state type.
// It has no dependencies; every module of the block imports it.
package css_pkg;

    localparam int REQ_W   = 2;
    localparam int IDX_W   = 6;
    localparam int VALUE_W = 16;
    localparam int DIV_W   = 5;
    localparam int LEN_W   = 7;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int LFSR_W  = 16;
    localparam int MOD_CNT_W = 4;

    localparam logic [REQ_W-1:0] REQ_PULSE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIVISIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACKWARD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANDOM   = 2'd2;

    localparam logic [DIV_W-1:0]  DIV_RESET    = 5'd4;
    localparam logic [LEN_W-1:0]  LEN_RESET    = 7'd16;
    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_FORWARD;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [IDX_W-1:0]   step_index;
        logic [VALUE_W-1:0] step_value;
    } css_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]   out_position;
        logic [VALUE_W-1:0] out_value;
        logic               value_valid;
    } css_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MOD_RAND,
        ST_MOD_WRAP
    } css_state_t;

endpackage

// File: rtl/clocked_step_sequencer_top.sv
// Top level of the clocked step sequencer: step memory, pulse divider and position sequencer.
// Depends on css_pkg for the item structs, codes and state type.
//
// Write and clear items, and clock pulses that do not end a step, complete in the idle state. A
// pulse that ends a step reads the step memory, loads the result register as soon as it is
// free, and then wraps the new position through a one-bit-per-cycle remainder unit over a
// 16-bit dividend; in random motion it first reduces the LFSR value through the same unit.
// s_ready is low from the memory read until the wrap is done. The step memory needs no
// clearing pass: one valid flip-flop per entry, cleared at reset, makes an unwritten entry
// read as zero.
module clocked_step_sequencer_top
    import css_pkg::*;
#(
    parameter int MAX_STEPS          = 64,
    parameter int PULSES_PER_QUARTER = 24,
    parameter int VALUE_BITS         = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  css_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output css_out_t             m_data
);

    localparam int PW = $clog2(MAX_STEPS);
    localparam int LW = $clog2(MAX_STEPS + 1);
    localparam int CW = $clog2(PULSES_PER_QUARTER + 1);
    localparam int SW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int IW = (PW > IDX_W) ? PW : IDX_W;
    localparam int NW = (LW > LEN_W) ? LW : LEN_W;
    localparam int DW = LFSR_W;
    localparam int DIV_N = 2 ** DIV_W;

    logic [DIV_W-1:0]  div_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [MODE_W-1:0] mode_reg;

    css_state_t state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [LFSR_W-1:0]    lfsr_reg, lfsr_next;
    logic [DW-1:0]        mod_div_reg, mod_div_next;
    logic [LW-1:0]        mod_rem_reg, mod_rem_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    css_out_t             m_data_reg, m_data_next;

    logic [SW-1:0] store_mem [MAX_STEPS];
    logic          store_vld_reg [MAX_STEPS];
    logic [SW-1:0] rd_data_reg;
    logic          rd_vld_reg;

    logic          rd_en;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [SW-1:0] wr_data;

    logic [CW-1:0]     thr_tab [DIV_N];
    logic [CW-1:0]     threshold;
    logic [NW-1:0]     len_ext;
    logic [LW-1:0]     act_len;
    logic [LW:0]       mod_try;
    logic [LW-1:0]     mod_rem_step;
    logic [LW-1:0]     addend;
    logic [CW-1:0]     count_inc;
    logic [LFSR_W-1:0] lfsr_step;
    logic [IW-1:0]     idx_ext;
    logic [IW-1:0]     pos_ext;
    logic              pos_ok;
    logic              s_fire;
    logic              out_free;

    for (genvar i = 0; i < DIV_N; i++) begin : g_thr
        localparam int D = (i == 0) ? 1 :
                           ((i > PULSES_PER_QUARTER) ? PULSES_PER_QUARTER : i);
        localparam int T = PULSES_PER_QUARTER / D;
        assign thr_tab[i] = CW'(T);
    end

    assign threshold = thr_tab[div_reg];
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign idx_ext   = IW'(s_data.step_index);
    assign pos_ext   = IW'(pos_reg);
    assign count_inc = count_reg + CW'(1);
    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : '0);

    always_comb begin
        len_ext = NW'(len_reg);
        if (len_ext == '0) begin
            act_len = LW'(1);
        end else if (len_ext > NW'(MAX_STEPS)) begin
            act_len = LW'(MAX_STEPS);
        end else begin
            act_len = len_ext[LW-1:0];
        end
    end

    assign pos_ok  = (32'(pos_reg) < 32'(act_len));
    assign mod_try = {mod_rem_reg, mod_div_reg[DW-1]};

    always_comb begin
        if (mod_try >= {1'b0, act_len}) begin
            mod_rem_step = LW'(mod_try - {1'b0, act_len});
        end else begin
            mod_rem_step = mod_try[LW-1:0];
        end
    end

    always_comb begin
        case (mode_reg)
            MODE_BACKWARD: addend = act_len - LW'(1);
            default:       addend = LW'(1);
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        lfsr_next    = lfsr_reg;
        mod_div_next = mod_div_reg;
        mod_rem_next = mod_rem_reg;
        mod_cnt_next = mod_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = idx_ext[PW-1:0];
        wr_data      = (s_data.req_type == REQ_WRITE) ? s_data.step_value[SW-1:0] : '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.req_type) inside
                        REQ_PULSE: begin
                            if (count_inc >= threshold) begin
                                count_next = '0;
                                rd_en      = 1'b1;
                                state_next = ST_READ;
                                if (mode_reg == MODE_RANDOM) begin
                                    lfsr_next = lfsr_step;
                                end
                            end else begin
                                count_next = count_inc;
                            end
                        end
                        REQ_WRITE, REQ_CLEAR: begin
                            wr_en = (32'(s_data.step_index) < MAX_STEPS);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.out_position = pos_ext[IDX_W-1:0];
                    m_data_next.value_valid  = pos_ok;
                    m_data_next.out_value    = (pos_ok && rd_vld_reg) ?
                                               VALUE_W'(rd_data_reg) : '0;
                    mod_rem_next = '0;
                    mod_cnt_next = '0;
                    if (mode_reg == MODE_RANDOM) begin
                        mod_div_next = lfsr_reg;
                        state_next   = ST_MOD_RAND;
                    end else begin
                        mod_div_next = DW'(pos_reg) + DW'(addend);
                        state_next   = ST_MOD_WRAP;
                    end
                end
            end
            ST_MOD_RAND: begin
                mod_rem_next = mod_rem_step;
                mod_div_next = mod_div_reg << 1;
                mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
                if (mod_cnt_reg == '1) begin
                    mod_div_next = DW'(pos_reg) + DW'(mod_rem_step) + DW'(1);
                    mod_rem_next = '0;
                    state_next   = ST_MOD_WRAP;
                end
            end
            ST_MOD_WRAP: begin
                mod_rem_next = mod_rem_step;
                mod_div_next = mod_div_reg << 1;
                mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
                if (mod_cnt_reg == '1) begin
                    pos_next   = mod_rem_step[PW-1:0];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg     <= DIV_RESET;
            len_reg     <= LEN_RESET;
            mode_reg    <= MODE_RESET;
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            lfsr_reg    <= LFSR_SEED;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_DIVISIONS: div_reg  <= cfg_wdata[DIV_W-1:0];
                    CFG_LENGTH:    len_reg  <= cfg_wdata;
                    CFG_MOTION:    mode_reg <= cfg_wdata[MODE_W-1:0];
                    default: begin
                    end
                endcase
            end
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            lfsr_reg    <= lfsr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mod_div_reg <= mod_div_next;
        mod_rem_reg <= mod_rem_next;
        mod_cnt_reg <= mod_cnt_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_STEPS; i++) begin
                store_vld_reg[i] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                store_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= store_vld_reg[pos_reg];
            end
        end
    end

endmodule

// File: rtl/css_checker.sv
// Port-level checker for the clocked step sequencer, bound to the top level.
// Depends on css_pkg for the item structs and request codes.
module css_checker
    import css_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input css_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input css_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped before it was taken");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result item changed while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.value_valid |-> m_data.out_value == '0)
        else $error("step outside the length gave a non-zero value");

    a_no_result_from_store: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.req_type != REQ_PULSE |=> !$rose(m_valid))
        else $error("a store item produced a result item");

endmodule

bind clocked_step_sequencer_top css_checker u_css_checker (.*);
